// File: hw/rtl/rgb_to_ycbcr_chroma_subsample_assert.svh
// Assertion macros for the checker file of the colour converter.
`ifndef RGB_TO_YCBCR_CHROMA_SUBSAMPLE_ASSERT_SVH
`define RGB_TO_YCBCR_CHROMA_SUBSAMPLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define YCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ycc check failed");

// Next-cycle implication, disabled while reset is asserted.
`define YCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ycc check failed");

`endif

// File: hw/rtl/ycc_pkg.sv
// Types, constants and divide helpers for the RGB to YCbCr converter.
package ycc_pkg;

	localparam int DEFAULT_MAX_WIDTH  = 4096;
	localparam int DEFAULT_MAX_HEIGHT = 4096;

	localparam int DIM_W   = 13;
	localparam int MODE_W  = 2;
	localparam int INDEX_W = 2;

	localparam logic [INDEX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [INDEX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [INDEX_W-1:0] REG_MODE   = 2'd2;

	localparam logic [MODE_W-1:0] MODE_444 = 2'd0;
	localparam logic [MODE_W-1:0] MODE_422 = 2'd1;
	localparam logic [MODE_W-1:0] MODE_420 = 2'd2;

	// chroma pair sums and one line store entry (Cr in the upper half)
	localparam int SUM_W  = 9;
	localparam int LINE_W = 2 * SUM_W;

	// luma: (299 R + 587 G + 114 B + 500) / 1000
	localparam int Y_NUM_W = 18;
	localparam logic [Y_NUM_W-1:0] Y_COEF_R = 18'd299;
	localparam logic [Y_NUM_W-1:0] Y_COEF_G = 18'd587;
	localparam logic [Y_NUM_W-1:0] Y_COEF_B = 18'd114;
	localparam logic [Y_NUM_W-1:0] Y_ROUND  = 18'd500;

	// chroma: coefficients scaled by 10^6 / 32, numerator never negative, / 31250
	localparam int C_NUM_W = 23;
	localparam logic [C_NUM_W-1:0] C_HALF    = 23'd15625;
	localparam logic [C_NUM_W-1:0] CB_COEF_R = 23'd5273;
	localparam logic [C_NUM_W-1:0] CB_COEF_G = 23'd10352;
	localparam logic [C_NUM_W-1:0] CR_COEF_G = 23'd13084;
	localparam logic [C_NUM_W-1:0] CR_COEF_B = 23'd2541;
	localparam logic [C_NUM_W-1:0] C_OFFSET  = 23'd4015625;

	// reciprocals: /1000 as (n>>3)*33555>>22, /31250 as (n>>1)*4398047>>36,
	// both exact over the numerator ranges
	localparam int LUMA_RECIP_W = 16;
	localparam logic [LUMA_RECIP_W-1:0] LUMA_RECIP = 16'd33555;
	localparam int LUMA_SHIFT  = 22;
	localparam int LUMA_PROD_W = (Y_NUM_W - 3) + LUMA_RECIP_W;

	localparam int CHROMA_RECIP_W = 23;
	localparam logic [CHROMA_RECIP_W-1:0] CHROMA_RECIP = 23'd4398047;
	localparam int CHROMA_SHIFT  = 36;
	localparam int CHROMA_PROD_W = (C_NUM_W - 1) + CHROMA_RECIP_W;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} ycc_pixel_t;

	typedef struct packed {
		logic [7:0] luma;
		logic       chroma_valid;
		logic [7:0] chroma_blue;
		logic [7:0] chroma_red;
		logic       frame_end;
	} ycc_result_t;

	typedef struct packed {
		logic last_col;
		logic last_row;
		logic odd_col;
		logic odd_row;
	} ycc_pos_t;

	// stage loads and line store / pending-sum strobes
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_out;
		logic rd_line;
		logic commit;
	} ycc_ctl_t;

	function automatic logic [7:0] luma_div(input logic [Y_NUM_W-1:0] num);
		logic [Y_NUM_W-4:0]     n8;
		logic [LUMA_PROD_W-1:0] prod;
		logic [8:0]             q;
		n8   = num[Y_NUM_W-1:3];
		prod = LUMA_PROD_W'(n8) * LUMA_PROD_W'(LUMA_RECIP);
		q    = prod[LUMA_PROD_W-1:LUMA_SHIFT];
		return (q > 9'd255) ? 8'hFF : q[7:0];
	endfunction

	function automatic logic [7:0] chroma_div(input logic [C_NUM_W-1:0] num);
		logic [C_NUM_W-2:0]       n2;
		logic [CHROMA_PROD_W-1:0] prod;
		logic [8:0]               q;
		n2   = num[C_NUM_W-1:1];
		prod = CHROMA_PROD_W'(n2) * CHROMA_PROD_W'(CHROMA_RECIP);
		q    = prod[CHROMA_PROD_W-1:CHROMA_SHIFT];
		return (q > 9'd255) ? 8'hFF : q[7:0];
	endfunction

endpackage

// File: hw/rtl/ycc_convert.sv
// Per-pixel colour matrix: input register, scaled sums, rounded Y/Cb/Cr.
module ycc_convert (
	input  logic                 clk,
	input  ycc_pkg::ycc_ctl_t    ctl,
	input  ycc_pkg::ycc_pixel_t  pixel,
	output logic [7:0]           luma_s3,
	output logic [7:0]           cb_s3,
	output logic [7:0]           cr_s3
);

	ycc_pkg::ycc_pixel_t                pix_s1;
	logic [ycc_pkg::Y_NUM_W-1:0]        y_num_s2;
	logic [ycc_pkg::C_NUM_W-1:0]        cb_num_s2;
	logic [ycc_pkg::C_NUM_W-1:0]        cr_num_s2;
	logic [ycc_pkg::Y_NUM_W-1:0]        y_num_d;
	logic [ycc_pkg::C_NUM_W-1:0]        cb_num_d;
	logic [ycc_pkg::C_NUM_W-1:0]        cr_num_d;

	// subtraction order keeps every partial result non-negative
	always_comb begin
		y_num_d = ycc_pkg::Y_NUM_W'(pix_s1.red) * ycc_pkg::Y_COEF_R
			+ ycc_pkg::Y_NUM_W'(pix_s1.green) * ycc_pkg::Y_COEF_G
			+ ycc_pkg::Y_NUM_W'(pix_s1.blue) * ycc_pkg::Y_COEF_B
			+ ycc_pkg::Y_ROUND;
		cb_num_d = ycc_pkg::C_OFFSET
			+ ycc_pkg::C_NUM_W'(pix_s1.blue) * ycc_pkg::C_HALF
			- ycc_pkg::C_NUM_W'(pix_s1.red) * ycc_pkg::CB_COEF_R
			- ycc_pkg::C_NUM_W'(pix_s1.green) * ycc_pkg::CB_COEF_G;
		cr_num_d = ycc_pkg::C_OFFSET
			+ ycc_pkg::C_NUM_W'(pix_s1.red) * ycc_pkg::C_HALF
			- ycc_pkg::C_NUM_W'(pix_s1.green) * ycc_pkg::CR_COEF_G
			- ycc_pkg::C_NUM_W'(pix_s1.blue) * ycc_pkg::CR_COEF_B;
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			pix_s1 <= pixel;
		end
		if (ctl.ld_s2) begin
			y_num_s2  <= y_num_d;
			cb_num_s2 <= cb_num_d;
			cr_num_s2 <= cr_num_d;
		end
		if (ctl.ld_s3) begin
			luma_s3 <= ycc_pkg::luma_div(y_num_s2);
			cb_s3   <= ycc_pkg::chroma_div(cb_num_s2);
			cr_s3   <= ycc_pkg::chroma_div(cr_num_s2);
		end
	end

endmodule

// File: hw/rtl/ycc_chroma.sv
// Chroma box averaging with pending pair sums, line store and result register.
module ycc_chroma #(
	parameter int LINE_DEPTH = 2048,
	parameter int AW         = 11
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ycc_pkg::ycc_ctl_t            ctl,
	input  logic [ycc_pkg::MODE_W-1:0]   mode,
	input  ycc_pkg::ycc_pos_t            pos_s3,
	input  logic [AW-1:0]                idx_s2,
	input  logic [AW-1:0]                idx_s3,
	input  logic [7:0]                   luma_s3,
	input  logic [7:0]                   cb_s3,
	input  logic [7:0]                   cr_s3,
	output ycc_pkg::ycc_result_t         res_s4
);

	logic [ycc_pkg::LINE_W-1:0] line_mem [LINE_DEPTH];
	logic [ycc_pkg::LINE_W-1:0] line_s3;
	logic [ycc_pkg::SUM_W-1:0]  pend_blue_q;
	logic [ycc_pkg::SUM_W-1:0]  pend_red_q;

	logic                       is_sub;
	logic                       is_420;
	logic                       close_blk;
	logic                       use_above;
	logic                       emit;
	logic [1:0]                 shift;
	logic [ycc_pkg::SUM_W-1:0]  pair_blue;
	logic [ycc_pkg::SUM_W-1:0]  pair_red;
	logic [ycc_pkg::LINE_W-1:0] wr_data;
	logic                       wr_en;
	logic                       pend_en;
	ycc_pkg::ycc_result_t       res_d;

	function automatic logic [7:0] box_avg(
		input logic [ycc_pkg::SUM_W-1:0] pair,
		input logic [ycc_pkg::SUM_W-1:0] above,
		input logic                      add_above,
		input logic [1:0]                sh
	);
		logic [ycc_pkg::SUM_W:0] total;
		logic [ycc_pkg::SUM_W:0] rounded;
		logic [ycc_pkg::SUM_W:0] q;
		total = (ycc_pkg::SUM_W + 1)'(pair)
			+ (add_above ? (ycc_pkg::SUM_W + 1)'(above) : '0);
		case (sh)
			2'd0:    rounded = total;
			2'd1:    rounded = total + 10'd1;
			default: rounded = total + 10'd2;
		endcase
		q = rounded >> sh;
		return (q > 10'd255) ? 8'hFF : q[7:0];
	endfunction

	always_comb begin
		is_sub    = (mode == ycc_pkg::MODE_422) || (mode == ycc_pkg::MODE_420);
		is_420    = (mode == ycc_pkg::MODE_420);
		close_blk = pos_s3.odd_col || pos_s3.last_col;
		use_above = is_420 && pos_s3.odd_row;
		shift     = {1'b0, pos_s3.odd_col} + {1'b0, use_above};
		pair_blue = pos_s3.odd_col ? pend_blue_q + ycc_pkg::SUM_W'(cb_s3)
			: ycc_pkg::SUM_W'(cb_s3);
		pair_red  = pos_s3.odd_col ? pend_red_q + ycc_pkg::SUM_W'(cr_s3)
			: ycc_pkg::SUM_W'(cr_s3);
		wr_data   = {pair_red, pair_blue};
		// even rows of 4:2:0 hold back their sample unless no odd row follows
		emit      = !is_sub || (close_blk && (!is_420 || pos_s3.odd_row || pos_s3.last_row));
		wr_en     = ctl.commit && is_420 && close_blk && !pos_s3.odd_row;
		pend_en   = ctl.commit && is_sub && !pos_s3.odd_col;

		res_d.luma         = luma_s3;
		res_d.chroma_valid = emit;
		res_d.frame_end    = pos_s3.last_col && pos_s3.last_row;
		if (!emit) begin
			res_d.chroma_blue = 8'd0;
			res_d.chroma_red  = 8'd0;
		end else if (!is_sub) begin
			res_d.chroma_blue = cb_s3;
			res_d.chroma_red  = cr_s3;
		end else begin
			res_d.chroma_blue = box_avg(pair_blue, line_s3[ycc_pkg::SUM_W-1:0],
				use_above, shift);
			res_d.chroma_red  = box_avg(pair_red,
				line_s3[ycc_pkg::LINE_W-1:ycc_pkg::SUM_W], use_above, shift);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[idx_s3] <= wr_data;
		end
	end

	// read for the request entering stage 3; forward a write to the same entry
	always_ff @(posedge clk) begin
		if (ctl.rd_line) begin
			if (wr_en && (idx_s3 == idx_s2)) begin
				line_s3 <= wr_data;
			end else begin
				line_s3 <= line_mem[idx_s2];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_blue_q <= '0;
			pend_red_q  <= '0;
		end else if (pend_en) begin
			pend_blue_q <= ycc_pkg::SUM_W'(cb_s3);
			pend_red_q  <= ycc_pkg::SUM_W'(cr_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_out) begin
			res_s4 <= res_d;
		end
	end

endmodule

// File: hw/rtl/rgb_to_ycbcr_chroma_subsample.sv
// Top level: configuration registers, raster position and pipeline handshake.
//
//   channel   direction  handshake                 payload
//   pixel     in         pixel_valid/pixel_ready   ycc_pixel_t  (red, green, blue)
//   result    out        result_valid/result_ready ycc_result_t (luma, chroma, frame_end)
//   cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One request per clock unless the result side stalls; each taken pixel passes through
// the input register, scaled sums, reciprocal divide and chroma average/result register.
// Stalls on the result side fill empty stages first, then lower pixel_ready.
// Reset clears the position, pending sums and stage valids; the line store is
// not cleared and needs no sweep. cfg_ready is always high.
module rgb_to_ycbcr_chroma_subsample #(
	parameter int MAX_WIDTH  = ycc_pkg::DEFAULT_MAX_WIDTH,
	parameter int MAX_HEIGHT = ycc_pkg::DEFAULT_MAX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pixel_valid,
	output logic                          pixel_ready,
	input  ycc_pkg::ycc_pixel_t           pixel,
	output logic                          result_valid,
	input  logic                          result_ready,
	output ycc_pkg::ycc_result_t          result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ycc_pkg::INDEX_W-1:0]   cfg_index,
	input  logic [ycc_pkg::DIM_W-1:0]     cfg_data
);

	localparam int CW         = $clog2(MAX_WIDTH);
	localparam int RW         = $clog2(MAX_HEIGHT);
	localparam int WW         = (CW + 1 > ycc_pkg::DIM_W) ? CW + 1 : ycc_pkg::DIM_W;
	localparam int HW         = (RW + 1 > ycc_pkg::DIM_W) ? RW + 1 : ycc_pkg::DIM_W;
	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	logic [ycc_pkg::DIM_W-1:0]  width_q;
	logic [ycc_pkg::DIM_W-1:0]  height_q;
	logic [ycc_pkg::MODE_W-1:0] mode_q;
	logic [CW-1:0]              col_q;
	logic [RW-1:0]              row_q;

	logic [WW-1:0]              w_eff;
	logic [HW-1:0]              h_eff;
	ycc_pkg::ycc_pos_t          pos_d;
	logic [AW-1:0]              idx_d;
	logic                       pix_acc;

	logic                       v_s1, v_s2, v_s3, v_s4;
	logic                       en_s1, en_s2, en_s3, en_s4;
	ycc_pkg::ycc_pos_t          pos_s1, pos_s2, pos_s3;
	logic [AW-1:0]              idx_s1, idx_s2, idx_s3;
	ycc_pkg::ycc_ctl_t          ctl;
	logic [7:0]                 luma_s3, cb_s3, cr_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ycc_pkg::DIM_W'(1);
			height_q <= ycc_pkg::DIM_W'(1);
			mode_q   <= ycc_pkg::MODE_444;
		end else if (cfg_valid) begin
			case (cfg_index)
				ycc_pkg::REG_WIDTH:  width_q  <= cfg_data;
				ycc_pkg::REG_HEIGHT: height_q <= cfg_data;
				ycc_pkg::REG_MODE:   mode_q   <= cfg_data[ycc_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, oversize as the maximum
	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (WW'(width_q) > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (HW'(height_q) > HW'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
		pos_d.last_col = (WW'(col_q) + WW'(1)) >= w_eff;
		pos_d.last_row = (HW'(row_q) + HW'(1)) >= h_eff;
		pos_d.odd_col  = col_q[0];
		pos_d.odd_row  = row_q[0];
		idx_d          = AW'(col_q >> 1);
	end

	assign en_s4       = !v_s4 || result_ready;
	assign en_s3       = !v_s3 || en_s4;
	assign en_s2       = !v_s2 || en_s3;
	assign en_s1       = !v_s1 || en_s2;
	assign pixel_ready = en_s1;
	assign pix_acc     = pixel_valid && en_s1;

	assign ctl.ld_s1   = en_s1;
	assign ctl.ld_s2   = en_s2;
	assign ctl.ld_s3   = en_s3;
	assign ctl.ld_out  = en_s4;
	assign ctl.rd_line = en_s3 && v_s2;
	assign ctl.commit  = en_s4 && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (pos_d.last_col) begin
				col_q <= '0;
				row_q <= pos_d.last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pixel_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pos_s1 <= pos_d;
			idx_s1 <= idx_d;
		end
		if (en_s2) begin
			pos_s2 <= pos_s1;
			idx_s2 <= idx_s1;
		end
		if (en_s3) begin
			pos_s3 <= pos_s2;
			idx_s3 <= idx_s2;
		end
	end

	ycc_convert u_convert (
		.clk     (clk),
		.ctl     (ctl),
		.pixel   (pixel),
		.luma_s3 (luma_s3),
		.cb_s3   (cb_s3),
		.cr_s3   (cr_s3)
	);

	ycc_chroma #(
		.LINE_DEPTH (LINE_DEPTH),
		.AW         (AW)
	) u_chroma (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.mode    (mode_q),
		.pos_s3  (pos_s3),
		.idx_s2  (idx_s2),
		.idx_s3  (idx_s3),
		.luma_s3 (luma_s3),
		.cb_s3   (cb_s3),
		.cr_s3   (cr_s3),
		.res_s4  (result)
	);

	assign result_valid = v_s4;

endmodule

// File: hw/rtl/ycc_checker.sv
// Port-level checks on the colour converter, bound to the top level.
`include "rgb_to_ycbcr_chroma_subsample_assert.svh"

module ycc_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 pixel_valid,
	input logic                 pixel_ready,
	input logic                 result_valid,
	input logic                 result_ready,
	input ycc_pkg::ycc_result_t result
);

	localparam logic [2:0] FULL = 3'd4;

	logic       in_acc;
	logic       out_acc;
	logic [2:0] count_q;

	assign in_acc  = pixel_valid && pixel_ready;
	assign out_acc = result_valid && result_ready;

	// requests taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	`YCC_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))
	`YCC_ASSERT_IMPL(a_result_owed, clk, arst_n, result_valid, count_q != 3'd0)
	`YCC_ASSERT_IMPL(a_full_stall, clk, arst_n, (count_q == FULL) && !result_ready, !pixel_ready)
	`YCC_ASSERT_IMPL(a_empty_ready, clk, arst_n, count_q == 3'd0, pixel_ready)
	`YCC_ASSERT_IMPL(a_chroma_idle, clk, arst_n, result_valid && !result.chroma_valid, (result.chroma_blue == 8'd0) && (result.chroma_red == 8'd0))

endmodule

bind rgb_to_ycbcr_chroma_subsample ycc_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pixel_valid  (pixel_valid),
	.pixel_ready  (pixel_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

// File: sim/rgb_to_ycbcr_chroma_subsample_tb.sv
// Self-checking testbench for the RGB to YCbCr converter with chroma subsampling.
module rgb_to_ycbcr_chroma_subsample_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_DEPTH = (ycc_pkg::DEFAULT_MAX_WIDTH + 1) / 2;
	localparam int RANDOM_ITEMS = 1200;
	localparam int LONG_HOLD = 300;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [ycc_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [ycc_pkg::INDEX_W-1:0] REG_SPARE = 2'd3;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_COIN,
		READY_MOSTLY,
		READY_PERIODIC
	} ready_style_e;

	// Mirror of the converter: registers, raster position, pair sums and the results due.
	class ycc_frame_state;
		logic [ycc_pkg::DIM_W-1:0] img_width = 1;
		logic [ycc_pkg::DIM_W-1:0] img_height = 1;
		logic [ycc_pkg::MODE_W-1:0] mode = ycc_pkg::MODE_444;
		int unsigned col_pos = 0;
		int unsigned row_pos = 0;
		int unsigned pend_cb = 0;
		int unsigned pend_cr = 0;
		bit [ycc_pkg::LINE_W-1:0] line_store [LINE_DEPTH];
		ycc_pkg::ycc_result_t results_due [$];
		int unsigned pixels_taken = 0;
		int unsigned errors = 0;

		function void write_reg(logic [ycc_pkg::INDEX_W-1:0] idx,
				logic [ycc_pkg::DIM_W-1:0] data);
			case (idx)
				ycc_pkg::REG_WIDTH: img_width = data;
				ycc_pkg::REG_HEIGHT: img_height = data;
				ycc_pkg::REG_MODE: mode = data[ycc_pkg::MODE_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned clamp_dim(int unsigned v, int unsigned max);
			if (v == 0)
				return 1;
			return (v > max) ? max : v;
		endfunction

		function int unsigned frame_pixels();
			return clamp_dim(img_width, ycc_pkg::DEFAULT_MAX_WIDTH)
				* clamp_dim(img_height, ycc_pkg::DEFAULT_MAX_HEIGHT);
		endfunction

		// scaled by 10^6, half up, clamped to a byte
		function int unsigned round_clamp(longint scaled);
			longint v;
			v = scaled + 500000;
			if (v < 0)
				return 0;
			v = v / 1000000;
			return (v > 255) ? 255 : int'(v);
		endfunction

		function void take_pixel(ycc_pkg::ycc_pixel_t p);
			longint r, g, b;
			int unsigned w, h, cb, cr, sum_b, sum_r, cnt, idx, avg_b, avg_r;
			bit last_col, last_row, odd_col, odd_row, emit;
			bit [ycc_pkg::LINE_W-1:0] entry;
			ycc_pkg::ycc_result_t predicted;
			r = p.red;
			g = p.green;
			b = p.blue;
			w = clamp_dim(img_width, ycc_pkg::DEFAULT_MAX_WIDTH);
			h = clamp_dim(img_height, ycc_pkg::DEFAULT_MAX_HEIGHT);
			last_col = (col_pos + 1 >= w);
			last_row = (row_pos + 1 >= h);
			odd_col = col_pos[0];
			odd_row = row_pos[0];
			predicted = '0;
			predicted.luma = 8'(round_clamp(299000 * r + 587000 * g + 114000 * b));
			cb = round_clamp(-168736 * r - 331264 * g + 500000 * b + 128000000);
			cr = round_clamp(500000 * r - 418688 * g - 81312 * b + 128000000);
			if (mode == ycc_pkg::MODE_422 || mode == ycc_pkg::MODE_420) begin
				if (!odd_col) begin
					pend_cb = cb;
					pend_cr = cr;
				end
				if (odd_col || last_col) begin
					sum_b = odd_col ? pend_cb + cb : cb;
					sum_r = odd_col ? pend_cr + cr : cr;
					cnt = odd_col ? 2 : 1;
					idx = col_pos >> 1;
					emit = 1'b1;
					if (mode == ycc_pkg::MODE_420) begin
						if (!odd_row) begin
							line_store[idx] = {ycc_pkg::SUM_W'(sum_r),
								ycc_pkg::SUM_W'(sum_b)};
							emit = last_row;
						end else begin
							entry = line_store[idx];
							sum_b += entry[ycc_pkg::SUM_W-1:0];
							sum_r += entry[ycc_pkg::LINE_W-1:ycc_pkg::SUM_W];
							cnt *= 2;
						end
					end
					if (emit) begin
						avg_b = (sum_b + cnt / 2) / cnt;
						avg_r = (sum_r + cnt / 2) / cnt;
						predicted.chroma_valid = 1'b1;
						predicted.chroma_blue = (avg_b > 255) ? 8'hFF : 8'(avg_b);
						predicted.chroma_red = (avg_r > 255) ? 8'hFF : 8'(avg_r);
					end
				end
			end else begin
				predicted.chroma_valid = 1'b1;
				predicted.chroma_blue = 8'(cb);
				predicted.chroma_red = 8'(cr);
			end
			predicted.frame_end = last_col && last_row;
			if (last_col) begin
				col_pos = 0;
				row_pos = last_row ? 0 : row_pos + 1;
			end else begin
				col_pos++;
			end
			pixels_taken++;
			results_due.push_back(predicted);
		endfunction

		function void compare_field(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			end
		endfunction

		function void check_result(ycc_pkg::ycc_result_t got);
			ycc_pkg::ycc_result_t want;
			if (results_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %p, expected none", $time, got);
				return;
			end
			want = results_due.pop_front();
			compare_field("luma", want.luma, got.luma);
			compare_field("chroma_valid", 8'(want.chroma_valid), 8'(got.chroma_valid));
			compare_field("chroma_blue", want.chroma_blue, got.chroma_blue);
			compare_field("chroma_red", want.chroma_red, got.chroma_red);
			compare_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pixel_valid = 1'b0;
	logic pixel_ready;
	ycc_pkg::ycc_pixel_t pixel = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	ycc_pkg::ycc_result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ycc_pkg::INDEX_W-1:0] cfg_index = '0;
	logic [ycc_pkg::DIM_W-1:0] cfg_data = '0;

	ycc_frame_state frame = new();
	bit steady = 1'b0;
	bit hold_request = 1'b0;
	int unsigned burst_left = 0;
	ready_style_e ready_style = READY_ALWAYS;
	int unsigned pattern_left = 0;
	int unsigned hold_count = 0;
	int unsigned cycle_count = 0;

	rgb_to_ycbcr_chroma_subsample DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel(pixel),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5ns clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side: check each accepted result, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				frame.check_result(result);
			if (pattern_left == 0) begin
				ready_style <= ready_style_e'($urandom_range(0, 3));
				pattern_left <= $urandom_range(50, 300);
			end else begin
				pattern_left <= pattern_left - 1;
			end
			if (hold_request && hold_count < LONG_HOLD) begin
				result_ready <= 1'b0;
				hold_count <= hold_count + 1;
			end else begin
				if (!hold_request)
					hold_count <= 0;
				case (ready_style)
					READY_ALWAYS: result_ready <= 1'b1;
					READY_COIN: result_ready <= 1'($urandom_range(0, 1));
					READY_MOSTLY: result_ready <= ($urandom_range(0, 9) != 0);
					default: result_ready <= (pattern_left % 4 != 0);
				endcase
			end
		end
	end

	function automatic logic [7:0] random_level();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic ycc_pkg::ycc_pixel_t random_pixel();
		ycc_pkg::ycc_pixel_t p;
		p.red = random_level();
		p.green = random_level();
		p.blue = random_level();
		return p;
	endfunction

	// called at a rising edge; valid is left high for a following request
	task automatic send_pixel(ycc_pkg::ycc_pixel_t p);
		pixel <= p;
		pixel_valid <= 1'b1;
		do @(posedge clk); while (!pixel_ready);
		frame.take_pixel(p);
	endtask

	task automatic send_stream(int unsigned n);
		int unsigned gap;
		for (int unsigned i = 0; i < n; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = steady ? 0 : $urandom_range(0, 6);
				if (gap > 0) begin
					pixel_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			send_pixel(random_pixel());
			burst_left--;
		end
	endtask

	task automatic finish_frame();
		while (frame.col_pos != 0 || frame.row_pos != 0)
			send_stream(1);
	endtask

	task automatic wait_results();
		pixel_valid <= 1'b0;
		do @(posedge clk); while (frame.results_due.size() != 0);
	endtask

	task automatic write_reg(logic [ycc_pkg::INDEX_W-1:0] idx,
			logic [ycc_pkg::DIM_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		frame.write_reg(idx, data);
	endtask

	task automatic set_config(logic [ycc_pkg::DIM_W-1:0] width_val,
			logic [ycc_pkg::DIM_W-1:0] height_val, logic [ycc_pkg::MODE_W-1:0] mode_val);
		wait_results();
		write_reg(ycc_pkg::REG_WIDTH, width_val);
		write_reg(ycc_pkg::REG_HEIGHT, height_val);
		write_reg(ycc_pkg::REG_MODE, ycc_pkg::DIM_W'(mode_val));
		write_reg(REG_SPARE, ycc_pkg::DIM_W'($urandom_range(0, 8191)));
		cfg_valid <= 1'b0;
	endtask

	task automatic change_reg(logic [ycc_pkg::INDEX_W-1:0] idx,
			logic [ycc_pkg::DIM_W-1:0] data);
		wait_results();
		write_reg(idx, data);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned w, h, start;
		logic [ycc_pkg::MODE_W-1:0] m;
		bit hold_done;
		ycc_pkg::ycc_pixel_t corners [7];
		logic [ycc_pkg::MODE_W-1:0] flat_modes [3];
		corners = '{'{8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF}, '{8'hFF, 8'h00, 8'h00},
			'{8'h00, 8'hFF, 8'h00}, '{8'h00, 8'h00, 8'hFF}, '{8'hFF, 8'hFF, 8'h00},
			'{8'h00, 8'hFF, 8'hFF}};
		flat_modes = '{ycc_pkg::MODE_444, ycc_pkg::MODE_422, MODE_UNUSED};
		hold_done = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: single-pixel frames in 4:4:4, colour corners hit the clamps
		foreach (corners[i])
			send_pixel(corners[i]);
		// zero sizes act as one, spare mode acts as 4:4:4
		set_config(ycc_pkg::DIM_W'(0), ycc_pkg::DIM_W'(0), MODE_UNUSED);
		send_stream(2);
		// odd right and bottom edges in 4:2:0
		set_config(ycc_pkg::DIM_W'(3), ycc_pkg::DIM_W'(3), ycc_pkg::MODE_420);
		send_stream(9);
		// 4:4:4 to 4:2:2 in mid-row: the odd column picks up stale pair sums
		set_config(ycc_pkg::DIM_W'(4), ycc_pkg::DIM_W'(1), ycc_pkg::MODE_444);
		send_stream(1);
		change_reg(ycc_pkg::REG_MODE, ycc_pkg::DIM_W'(ycc_pkg::MODE_422));
		send_stream(3);

		start = frame.pixels_taken;
		while (frame.pixels_taken - start < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: m = ycc_pkg::MODE_420;
				4, 5, 6: m = ycc_pkg::MODE_422;
				7, 8: m = ycc_pkg::MODE_444;
				default: m = MODE_UNUSED;
			endcase
			case ($urandom_range(0, 19))
				0: w = 0;
				15, 16, 17, 18: w = $urandom_range(9, 48);
				19: w = $urandom_range(49, 200);
				default: w = $urandom_range(1, 8);
			endcase
			case ($urandom_range(0, 19))
				0: h = 0;
				1, 2: h = $urandom_range(6, 9);
				default: h = $urandom_range(1, 5);
			endcase
			steady = ($urandom_range(0, 3) == 0);
			set_config(ycc_pkg::DIM_W'(w), ycc_pkg::DIM_W'(h), m);
			// size or mode changes in mid-image stay clear of 4:2:0 so the line store is
			// always filled by an even row before it is read
			if (m != ycc_pkg::MODE_420 && $urandom_range(0, 3) == 0) begin
				send_stream($urandom_range(1, frame.frame_pixels()));
				case ($urandom_range(0, 2))
					0: change_reg(ycc_pkg::REG_WIDTH, ycc_pkg::DIM_W'($urandom_range(0, 12)));
					1: change_reg(ycc_pkg::REG_HEIGHT, ycc_pkg::DIM_W'($urandom_range(0, 6)));
					default: change_reg(ycc_pkg::REG_MODE,
						ycc_pkg::DIM_W'(flat_modes[$urandom_range(0, 2)]));
				endcase
			end else begin
				send_stream($urandom_range(1, 3) * frame.frame_pixels());
			end
			// long receiver hold-off while requests keep coming, so the input backs up
			if (!hold_done && frame.pixels_taken - start > RANDOM_ITEMS / 4) begin
				hold_request = 1'b1;
				steady = 1'b1;
				send_stream(40);
				hold_request = 1'b0;
				hold_done = 1'b1;
			end
			finish_frame();
		end

		wait_results();
		repeat (20) @(posedge clk);
		if (frame.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
